>>> hdl/alicp_pkg.sv
// ---------------------------------------------------------------------------
// alicp_pkg
// Shared types and constants for the array list insert/count/purge unit.
// ---------------------------------------------------------------------------
`default_nettype none

package alicp_pkg;

  // Default store depth
  localparam int DEPTH_DEF = 1024;

  // Field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 11;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int CNTO_W   = 11;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch a new word and set up the pass
    logic step;    // issue one memory read
    logic finish;  // final write and length update
    logic emit;    // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic more;     // reads left to issue
    logic pending;  // read data still in flight
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/array_list_insert_count_purge_unit.sv
// ---------------------------------------------------------------------------
// array_list_insert_count_purge_unit
// Ordered list of signed 32-bit values with insert, range count and
// range delete.
// ---------------------------------------------------------------------------
// One word is worked at a time; in_tready is high only while the unit is
// idle. The time per word is set by the pass over the element store, one
// entry per cycle: an insert at position p into a list of length L moves
// the L-p+1 entries from index p-1 up, a count or delete reads all L entries,
// and a rejected insert, an append, an unused operation or a scan of an
// empty list reads none. The result sits in an output register, so a new
// word can be taken while the previous result waits for out_tready. The
// store is not cleared at reset; only entries below the current length are
// ever read.
`default_nettype none

module array_list_insert_count_purge_unit #(
  parameter int DEPTH = alicp_pkg::DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [1:0] operation, [12:2] position, [44:13] operand_low,
  // [76:45] operand_high, [79:77] zero
  input  wire  [alicp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [1:0] status, [12:2] range_count, [23:13] list_length
  output logic [alicp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  alicp_pkg::cmd_t cmd;
  alicp_pkg::sts_t sts;

  logic [alicp_pkg::STAT_W-1:0] status;
  logic [alicp_pkg::CNTO_W-1:0] range_count;
  logic [alicp_pkg::CNTO_W-1:0] list_length;

  alicp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  alicp_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (in_tdata[1:0]),
    .position     (in_tdata[12:2]),
    .operand_low  (in_tdata[44:13]),
    .operand_high (in_tdata[76:45]),
    .status       (status),
    .range_count  (range_count),
    .list_length  (list_length)
  );

  assign out_tdata = {list_length, range_count, status};

endmodule

`default_nettype wire

>>> hdl/alicp_ctrl.sv
// ---------------------------------------------------------------------------
// alicp_ctrl
// Sequencer: accepts a word, runs the memory pass, hands out the result.
// ---------------------------------------------------------------------------
`default_nettype none

module alicp_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire               out_tready,
  input  alicp_pkg::sts_t   sts,
  output alicp_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  // Commands and next state
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.load   = in_tvalid && (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.more) begin
          cmd.step = 1'b1;
        end else if (!sts.pending) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result word valid flag
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/alicp_dpath.sv
// ---------------------------------------------------------------------------
// alicp_dpath
// Element store, pass counters, range compare and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module alicp_dpath #(
  parameter int DEPTH = alicp_pkg::DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  alicp_pkg::cmd_t                     cmd,
  output alicp_pkg::sts_t                     sts,
  input  wire        [alicp_pkg::OP_W-1:0]    operation,
  input  wire        [alicp_pkg::POS_W-1:0]   position,
  input  wire signed [alicp_pkg::VAL_W-1:0]   operand_low,
  input  wire signed [alicp_pkg::VAL_W-1:0]   operand_high,
  output logic       [alicp_pkg::STAT_W-1:0]  status,
  output logic       [alicp_pkg::CNTO_W-1:0]  range_count,
  output logic       [alicp_pkg::CNTO_W-1:0]  list_length
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > alicp_pkg::POS_W) ? CNT_W : alicp_pkg::POS_W) + 1;

  // Element store
  logic signed [alicp_pkg::VAL_W-1:0] mem [DEPTH];

  // Control state
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] rem_r;
  logic             rd_vld_r;

  // Per-word registers
  logic        [alicp_pkg::OP_W-1:0]   op_r;
  logic signed [alicp_pkg::VAL_W-1:0]  lo_r;
  logic signed [alicp_pkg::VAL_W-1:0]  hi_r;
  logic        [ADDR_W-1:0]            pidx_r;
  logic                                ins_ok_r;
  logic        [alicp_pkg::STAT_W-1:0] status_r;
  logic        [ADDR_W-1:0]            rd_ptr_r;
  logic        [ADDR_W-1:0]            rd_addr_r;
  logic signed [alicp_pkg::VAL_W-1:0]  rdata_r;
  logic        [CNT_W-1:0]             kept_r;
  logic        [CNT_W-1:0]             found_r;

  // Result registers
  logic [alicp_pkg::STAT_W-1:0] stat_o_r;
  logic [alicp_pkg::CNTO_W-1:0] cnt_o_r;
  logic [alicp_pkg::CNTO_W-1:0] len_o_r;

  // Setup for a new word
  logic [CMP_W-1:0]            pos_ext;
  logic [CMP_W-1:0]            len_ext;
  logic [CMP_W-1:0]            pos_m1;
  logic [CMP_W-1:0]            len_m1;
  logic [CMP_W-1:0]            rem_ins;
  logic                        is_ins;
  logic                        bad_pos;
  logic                        is_full;
  logic                        ins_ok;
  logic                        scan_op;
  logic [CNT_W-1:0]            ld_rem;
  logic [ADDR_W-1:0]           ld_ptr;
  logic [alicp_pkg::STAT_W-1:0] ld_status;

  always_comb begin
    pos_ext = CMP_W'(position);
    len_ext = CMP_W'(len_r);
    pos_m1  = pos_ext - CMP_W'(1);
    len_m1  = len_ext - CMP_W'(1);
    rem_ins = len_ext - pos_m1;
    is_ins  = (operation == alicp_pkg::OP_INSERT);
    scan_op = (operation == alicp_pkg::OP_COUNT) || (operation == alicp_pkg::OP_DELETE);
    bad_pos = is_ins && ((position == '0) || (pos_ext > (len_ext + CMP_W'(1))));
    is_full = is_ins && !bad_pos && (len_ext == CMP_W'(DEPTH));
    ins_ok  = is_ins && !bad_pos && !is_full;
    if (bad_pos) begin
      ld_status = alicp_pkg::ST_BADPOS;
    end else if (is_full) begin
      ld_status = alicp_pkg::ST_FULL;
    end else begin
      ld_status = alicp_pkg::ST_DONE;
    end
    // insert moves entries length-1 down to position-1, scans walk 0 up
    if (ins_ok) begin
      ld_rem = rem_ins[CNT_W-1:0];
      ld_ptr = len_m1[ADDR_W-1:0];
    end else if (scan_op) begin
      ld_rem = len_r;
      ld_ptr = '0;
    end else begin
      ld_rem = '0;
      ld_ptr = '0;
    end
  end

  // Range test on the word read last cycle
  logic hit;
  assign hit = (rdata_r >= lo_r) && (rdata_r <= hi_r);

  // Write port select
  logic                               we;
  logic [ADDR_W-1:0]                  waddr;
  logic signed [alicp_pkg::VAL_W-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = rd_addr_r + ADDR_W'(1);
    wdata = rdata_r;
    if (cmd.finish && ins_ok_r) begin
      we    = 1'b1;
      waddr = pidx_r;
      wdata = lo_r;
    end else if (rd_vld_r) begin
      case (op_r)
        alicp_pkg::OP_INSERT: we = 1'b1;
        alicp_pkg::OP_DELETE: begin
          we    = !hit;
          waddr = kept_r[ADDR_W-1:0];
        end
        default: we = 1'b0;
      endcase
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.step) rdata_r <= mem[rd_ptr_r];
  end

  // Length, read budget and read valid
  logic [CNT_W-1:0] len_nxt;

  always_comb begin
    len_nxt = len_r;
    if (cmd.finish) begin
      if (ins_ok_r) begin
        len_nxt = len_r + CNT_W'(1);
      end else if (op_r == alicp_pkg::OP_DELETE) begin
        len_nxt = kept_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      rem_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      rd_vld_r <= cmd.step;
      if (cmd.load) begin
        rem_r <= ld_rem;
      end else if (cmd.step) begin
        rem_r <= rem_r - CNT_W'(1);
      end
    end
  end

  // Per-word payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= operation;
      lo_r     <= operand_low;
      hi_r     <= operand_high;
      pidx_r   <= pos_m1[ADDR_W-1:0];
      ins_ok_r <= ins_ok;
      status_r <= ld_status;
      rd_ptr_r <= ld_ptr;
      kept_r   <= '0;
      found_r  <= '0;
    end else begin
      if (cmd.step) begin
        rd_addr_r <= rd_ptr_r;
        rd_ptr_r  <= (op_r == alicp_pkg::OP_INSERT) ? (rd_ptr_r - ADDR_W'(1))
                                                    : (rd_ptr_r + ADDR_W'(1));
      end
      if (rd_vld_r) begin
        if ((op_r == alicp_pkg::OP_COUNT) && hit) found_r <= found_r + CNT_W'(1);
        if ((op_r == alicp_pkg::OP_DELETE) && !hit) kept_r <= kept_r + CNT_W'(1);
      end
    end
  end

  // Result register, counts masked to the field width
  logic [CMP_W-1:0] found_ext;
  logic [CMP_W-1:0] len_out_ext;

  assign found_ext   = CMP_W'(found_r);
  assign len_out_ext = CMP_W'(len_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      stat_o_r <= status_r;
      cnt_o_r  <= (op_r == alicp_pkg::OP_COUNT) ? found_ext[alicp_pkg::CNTO_W-1:0] : '0;
      len_o_r  <= len_out_ext[alicp_pkg::CNTO_W-1:0];
    end
  end

  assign status      = stat_o_r;
  assign range_count = cnt_o_r;
  assign list_length = len_o_r;

  assign sts.more    = (rem_r != '0);
  assign sts.pending = rd_vld_r;

endmodule

`default_nettype wire

>>> hdl/alicp_chk.sv
// ---------------------------------------------------------------------------
// alicp_chk
// Port-level checks for the array list unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module alicp_chk (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [alicp_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // No result is offered out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  // Status code is never the unused value
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == alicp_pkg::ST_DONE) ||
                   (out_tdata[1:0] == alicp_pkg::ST_BADPOS) ||
                   (out_tdata[1:0] == alicp_pkg::ST_FULL))
    else $error("illegal status code");

  // A rejected insert carries no range count
  a_reject_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != alicp_pkg::ST_DONE) |-> out_tdata[12:2] == '0)
    else $error("range count on rejected insert");

endmodule

bind array_list_insert_count_purge_unit alicp_chk u_alicp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
